@@ sv/button_debounce_long_press_defines.svh @@
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Concurrent property wrappers on clk with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication
`define BDLP_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BDLP_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce package
// Sizes, register indexes, reset values and lane structs.
// ----------------------------------------------------------------------------
package bdlp_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int TIME_BITS   = 32;
	localparam int FIELD_W     = 3;
	localparam int TICK_W      = 16;
	localparam int CFG_IDX_W   = 2;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TICK_W-1:0]    ticks_t;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd3;

	localparam ticks_t             RST_DEBOUNCE   = 16'd50;
	localparam ticks_t             RST_LONG_PRESS = 16'd1000;
	localparam ticks_t             RST_REPEAT     = 16'd200;
	localparam logic [FIELD_W-1:0] RST_ACTIVE_LOW = 3'd1;

	typedef struct packed {
		ticks_t debounce_ticks;
		ticks_t long_press_ticks;
		ticks_t repeat_ticks;
	} cfg_t;

	typedef struct packed {
		logic held;
		logic press;
		logic long_flag;
		logic pulse;
	} lane_res_t;

endpackage

@@ sv/button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press and repeat
// Takes at most one millisecond tick beat per clock cycle and returns one
// result beat per tick. One lane per button resolves the tick
// combinationally. The merge stage registers the masks, so a result
// appears the cycle after its tick is taken. A new tick is taken when the
// result register is empty, or in the same cycle that its waiting result is
// taken; with result_ready held high, ticks stream back to back. Configuration
// writes apply from the next tick on.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_defines.svh"

module button_debounce_long_press import bdlp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  ticks_t               cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [FIELD_W-1:0]   raw_levels,
	input  logic [FIELD_W-1:0]   clear_press_mask,
	input  logic [FIELD_W-1:0]   clear_long_mask,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [FIELD_W-1:0]   held_mask,
	output logic [FIELD_W-1:0]   press_flags,
	output logic [FIELD_W-1:0]   long_flags,
	output logic [FIELD_W-1:0]   repeat_pulse
);

	cfg_t               cfg_q;
	logic [FIELD_W-1:0] active_low_q;
	time_t              tick_q;
	logic               step;
	logic [FIELD_W-1:0] readings;
	lane_res_t          res [NUM_BUTTONS];

	assign step     = item_valid && item_ready;
	assign readings = raw_levels ^ active_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks   <= RST_DEBOUNCE;
			cfg_q.long_press_ticks <= RST_LONG_PRESS;
			cfg_q.repeat_ticks     <= RST_REPEAT;
			active_low_q           <= RST_ACTIVE_LOW;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data;
				CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data;
				CFG_REPEAT:     cfg_q.repeat_ticks     <= cfg_data;
				CFG_ACTIVE_LOW: active_low_q           <= cfg_data[FIELD_W-1:0];
				default:        ;
			endcase
		end
	end

	// advance the millisecond time base once per tick beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (step) begin
			tick_q <= tick_q + time_t'(1);
		end
	end

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic rd;
		logic cp;
		logic cl;
		if (i < FIELD_W) begin : g_pin
			assign rd = readings[i];
			assign cp = clear_press_mask[i];
			assign cl = clear_long_mask[i];
		end else begin : g_nopin
			assign rd = 1'b0;
			assign cp = 1'b0;
			assign cl = 1'b0;
		end
		bdlp_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (step),
			.reading   (rd),
			.clr_press (cp),
			.clr_long  (cl),
			.now       (tick_q),
			.cfg       (cfg_q),
			.res       (res[i])
		);
	end

	bdlp_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.res          (res),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.held_mask    (held_mask),
		.press_flags  (press_flags),
		.long_flags   (long_flags),
		.repeat_pulse (repeat_pulse)
	);

	`BDLP_IMPLIES(a_pulse_held, result_valid, (repeat_pulse & ~held_mask) == '0, "pulse not held")
	`BDLP_NEXT(a_tick_advance, step, tick_q == $past(tick_q) + time_t'(1), "tick not advanced")
	`BDLP_NEXT(a_result_follows, step, result_valid, "no result after tick beat")

endmodule

@@ sv/bdlp_lane.sv @@
// ----------------------------------------------------------------------------
// Button debounce lane
// Per-button debounce, press and long-press flags and hold-repeat timing.
// ----------------------------------------------------------------------------
module bdlp_lane import bdlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      reading,
	input  logic      clr_press,
	input  logic      clr_long,
	input  time_t     now,
	input  cfg_t      cfg,
	output lane_res_t res
);

	logic  prev_q;
	logic  deb_q;
	logic  press_q;
	logic  long_q;
	logic  fired_q;
	time_t last_change_q;
	time_t press_start_q;
	time_t last_repeat_q;

	time_t since_change;
	time_t since_press;
	time_t since_repeat;
	logic  stable;
	logic  press_evt;
	logic  release_evt;
	logic  deb_nx;
	logic  long_hit;
	logic  fired_nx;
	logic  pulse;

	always_comb begin
		since_change = now - last_change_q;
		since_press  = now - press_start_q;
		since_repeat = now - last_repeat_q;
		stable       = (reading == prev_q) && (since_change > time_t'(cfg.debounce_ticks));
		press_evt    = stable && reading && !deb_q;
		release_evt  = stable && !reading && deb_q;
		deb_nx       = press_evt | (deb_q & ~release_evt);
		long_hit     = deb_nx && !fired_q && !press_evt
			&& (since_press > time_t'(cfg.long_press_ticks));
		fired_nx     = (fired_q && !release_evt) || long_hit;
		pulse        = deb_nx && fired_nx && (since_repeat > time_t'(cfg.repeat_ticks));
		res.held      = deb_nx;
		res.press     = press_q | press_evt;
		res.long_flag = long_q | long_hit;
		res.pulse     = pulse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= 1'b0;
			deb_q         <= 1'b0;
			press_q       <= 1'b0;
			long_q        <= 1'b0;
			fired_q       <= 1'b0;
			last_change_q <= '0;
			press_start_q <= '0;
			last_repeat_q <= '0;
		end else if (step) begin
			prev_q  <= reading;
			deb_q   <= deb_nx;
			press_q <= res.press & ~clr_press;
			long_q  <= res.long_flag & ~clr_long;
			fired_q <= fired_nx;
			if (reading != prev_q) begin
				last_change_q <= now;
			end
			if (press_evt) begin
				press_start_q <= now;
			end
			if (pulse) begin
				last_repeat_q <= now;
			end
		end
	end

endmodule

@@ sv/bdlp_merge.sv @@
// ----------------------------------------------------------------------------
// Button debounce merge stage
// Pack lane results into the result masks and hold them in the output register.
// ----------------------------------------------------------------------------
module bdlp_merge import bdlp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  lane_res_t          res [NUM_BUTTONS],
	output logic               item_ready,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [FIELD_W-1:0] held_mask,
	output logic [FIELD_W-1:0] press_flags,
	output logic [FIELD_W-1:0] long_flags,
	output logic [FIELD_W-1:0] repeat_pulse
);

	logic [FIELD_W-1:0] held_nx;
	logic [FIELD_W-1:0] press_nx;
	logic [FIELD_W-1:0] long_nx;
	logic [FIELD_W-1:0] pulse_nx;
	logic               valid_q;
	logic [FIELD_W-1:0] held_q;
	logic [FIELD_W-1:0] press_q;
	logic [FIELD_W-1:0] long_q;
	logic [FIELD_W-1:0] pulse_q;

	for (genvar b = 0; b < FIELD_W; b++) begin : g_pack
		if (b < NUM_BUTTONS) begin : g_lane
			assign held_nx[b]  = res[b].held;
			assign press_nx[b] = res[b].press;
			assign long_nx[b]  = res[b].long_flag;
			assign pulse_nx[b] = res[b].pulse;
		end else begin : g_none
			assign held_nx[b]  = 1'b0;
			assign press_nx[b] = 1'b0;
			assign long_nx[b]  = 1'b0;
			assign pulse_nx[b] = 1'b0;
		end
	end

	assign item_ready   = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign held_mask    = held_q;
	assign press_flags  = press_q;
	assign long_flags   = long_q;
	assign repeat_pulse = pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			held_q  <= held_nx;
			press_q <= press_nx;
			long_q  <= long_nx;
			pulse_q <= pulse_nx;
		end
	end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Button debounce with long press and repeat: testbench
// Sends tick beats in random bursts while the result side stalls on its own
// pattern. A scoreboard mirrors the per-button debounce, long press and repeat
// timing, and compares every result beat field by field. Each phase between
// idle points loads new register values, the extremes among them.
// ----------------------------------------------------------------------------
import bdlp_pkg::*;

typedef struct packed {
	logic [FIELD_W-1:0] held;
	logic [FIELD_W-1:0] press;
	logic [FIELD_W-1:0] long_hold;
	logic [FIELD_W-1:0] pulse;
} tick_result_t;

class tick_scoreboard;
	ticks_t             debounce_ticks;
	ticks_t             long_press_ticks;
	ticks_t             repeat_ticks;
	logic [FIELD_W-1:0] active_low;
	time_t              now_tick;
	logic [FIELD_W-1:0] prev_reading;
	logic [FIELD_W-1:0] held_bits;
	logic [FIELD_W-1:0] press_bits;
	logic [FIELD_W-1:0] long_bits;
	logic [FIELD_W-1:0] fired_bits;
	time_t              changed_at[NUM_BUTTONS];
	time_t              pressed_at[NUM_BUTTONS];
	time_t              repeated_at[NUM_BUTTONS];
	tick_result_t       expected_ticks[$];
	int                 checked;
	int                 mismatches;
	int                 errors;

	function new();
		int i;
		debounce_ticks   = RST_DEBOUNCE;
		long_press_ticks = RST_LONG_PRESS;
		repeat_ticks     = RST_REPEAT;
		active_low       = RST_ACTIVE_LOW;
		now_tick         = '0;
		prev_reading     = '0;
		held_bits        = '0;
		press_bits       = '0;
		long_bits        = '0;
		fired_bits       = '0;
		for (i = 0; i < NUM_BUTTONS; i++) begin
			changed_at[i]  = '0;
			pressed_at[i]  = '0;
			repeated_at[i] = '0;
		end
		checked    = 0;
		mismatches = 0;
		errors     = 0;
	endfunction

	function void set_reg(input logic [CFG_IDX_W-1:0] idx, input ticks_t data);
		case (idx)
		CFG_DEBOUNCE: debounce_ticks = data;
		CFG_LONG_PRESS: long_press_ticks = data;
		CFG_REPEAT: repeat_ticks = data;
		CFG_ACTIVE_LOW: active_low = data[FIELD_W-1:0];
		default: ;
		endcase
	endfunction

	function void note_tick(input logic [FIELD_W-1:0] levels, clr_press, clr_long);
		logic [FIELD_W-1:0] reading;
		logic [FIELD_W-1:0] pulses;
		time_t              span;
		tick_result_t       res;
		int                 i;
		reading = levels ^ active_low;
		pulses  = '0;
		for (i = 0; i < NUM_BUTTONS; i++) begin
			if (reading[i] != prev_reading[i])
				changed_at[i] = now_tick;
			span = now_tick - changed_at[i];
			if (span > time_t'(debounce_ticks) && reading[i] != held_bits[i]) begin
				if (reading[i]) begin
					held_bits[i]  = 1'b1;
					press_bits[i] = 1'b1;
					pressed_at[i] = now_tick;
				end else begin
					held_bits[i]  = 1'b0;
					fired_bits[i] = 1'b0;
				end
			end
			span = now_tick - pressed_at[i];
			if (held_bits[i] && !fired_bits[i] && span > time_t'(long_press_ticks)) begin
				long_bits[i]  = 1'b1;
				fired_bits[i] = 1'b1;
			end
			span = now_tick - repeated_at[i];
			if (held_bits[i] && fired_bits[i] && span > time_t'(repeat_ticks)) begin
				repeated_at[i] = now_tick;
				pulses[i]      = 1'b1;
			end
		end
		prev_reading  = reading;
		res.held      = held_bits;
		res.press     = press_bits;
		res.long_hold = long_bits;
		res.pulse     = pulses;
		expected_ticks.push_back(res);
		press_bits = press_bits & ~clr_press;
		long_bits  = long_bits & ~clr_long;
		now_tick   = now_tick + 1'b1;
	endfunction

	function void check_tick(input tick_result_t got);
		tick_result_t want;
		if (expected_ticks.size() == 0) begin
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("result beat with nothing pending: held %b press %b long %b pulse %b",
					got.held, got.press, got.long_hold, got.pulse);
		end else begin
			want = expected_ticks.pop_front();
			if (got.held !== want.held || got.press !== want.press ||
					got.long_hold !== want.long_hold || got.pulse !== want.pulse) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("tick %0d: held %b/%b press %b/%b long %b/%b pulse %b/%b (exp/got)",
						checked, want.held, got.held, want.press, got.press,
						want.long_hold, got.long_hold, want.pulse, got.pulse);
			end
			checked++;
		end
	endfunction

	function int pending();
		return expected_ticks.size();
	endfunction

	function void report_leftover();
		if (expected_ticks.size() != 0) begin
			errors += expected_ticks.size();
			$display("%0d result beats never arrived", expected_ticks.size());
		end
	endfunction
endclass

module tb_top;
	localparam int RESET_CYCLES   = 12;
	localparam int HOLD_OFF       = 300;
	localparam int IDLE_LIMIT     = 3000;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 125;
	localparam int PRESSURE_PHASE = 5;
	localparam int MAX_RUN_CAP    = 400;

	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_PATTERN} ready_mode_e;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	ticks_t               cfg_data;
	logic                 item_valid;
	logic                 item_ready;
	logic [FIELD_W-1:0]   raw_levels;
	logic [FIELD_W-1:0]   clear_press_mask;
	logic [FIELD_W-1:0]   clear_long_mask;
	logic                 result_valid;
	logic                 result_ready;
	logic [FIELD_W-1:0]   held_mask;
	logic [FIELD_W-1:0]   press_flags;
	logic [FIELD_W-1:0]   long_flags;
	logic [FIELD_W-1:0]   repeat_pulse;

	tick_scoreboard       sb = new();
	int                   idle_cycles = 0;
	bit                   hold_req = 1'b0;
	bit                   noisy = 1'b0;
	logic [FIELD_W-1:0]   seq_level = '0;
	int                   seq_left[NUM_BUTTONS] = '{default: 0};
	int                   max_run = 20;

	button_debounce_long_press DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.raw_levels       (raw_levels),
		.clear_press_mask (clear_press_mask),
		.clear_long_mask  (clear_long_mask),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.held_mask        (held_mask),
		.press_flags      (press_flags),
		.long_flags       (long_flags),
		.repeat_pulse     (repeat_pulse)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (item_valid && item_ready)
			sb.note_tick(raw_levels, clear_press_mask, clear_long_mask);
		if (result_valid && result_ready)
			sb.check_tick({held_mask, press_flags, long_flags, repeat_pulse});
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("tb_top: errors");
		$finish;
	end

	initial begin : result_side
		ready_mode_e mode;
		int          left;
		int          k;
		result_ready <= 1'b0;
		k = 0;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_OFF) begin
					@(posedge clk);
					result_ready <= 1'b0;
				end
			end else begin
				mode = ready_mode_e'($urandom_range(0, 3));
				left = $urandom_range(10, 150);
				while (left > 0 && !hold_req) begin
					@(posedge clk);
					k++;
					case (mode)
					RDY_ALWAYS: result_ready <= 1'b1;
					RDY_HALF: result_ready <= ($urandom_range(0, 1) == 0);
					RDY_MOSTLY: result_ready <= ($urandom_range(0, 3) != 0);
					default: result_ready <= ((k % 7) < 3);
					endcase
					left--;
				end
			end
		end
	end

	function automatic logic [FIELD_W-1:0] next_levels();
		logic [FIELD_W-1:0] lv;
		int                 i;
		if (noisy) begin
			lv = FIELD_W'($urandom_range(0, 7));
		end else begin
			for (i = 0; i < NUM_BUTTONS; i++) begin
				if (seq_left[i] == 0) begin
					seq_level[i] = ~seq_level[i];
					seq_left[i]  = $urandom_range(1, max_run);
				end
				seq_left[i]--;
			end
			lv = seq_level;
			if ($urandom_range(0, 15) == 0)
				lv[$urandom_range(0, NUM_BUTTONS - 1)] ^= 1'b1;
		end
		return lv;
	endfunction

	task automatic send_tick(input logic [FIELD_W-1:0] lv, cp, cl);
		item_valid       <= 1'b1;
		raw_levels       <= lv;
		clear_press_mask <= cp;
		clear_long_mask  <= cl;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic run_phase(input int n, input bit no_gaps);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < n) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
			while (burst > 0 && sent < n) begin
				send_tick(next_levels(),
					FIELD_W'($urandom_range(0, 7) & $urandom_range(0, 7)),
					FIELD_W'($urandom_range(0, 7) & $urandom_range(0, 7)));
				burst--;
				sent++;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (sent < n && gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input ticks_t db, lp, rp, input logic [FIELD_W-1:0] al);
		logic [CFG_IDX_W-1:0] idx[4];
		ticks_t               vals[4];
		int                   i;
		int                   span;
		idx  = '{CFG_DEBOUNCE, CFG_LONG_PRESS, CFG_REPEAT, CFG_ACTIVE_LOW};
		vals = '{db, lp, rp, {13'($urandom_range(0, 8191)), al}};
		for (i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
		span    = int'(db) + int'(lp) + 4 * int'(rp) + 10;
		max_run = (span > MAX_RUN_CAP) ? MAX_RUN_CAP : span;
	endtask

	initial begin : stimulus
		int p;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_DEBOUNCE;
		cfg_data         <= '0;
		item_valid       <= 1'b0;
		raw_levels       <= '0;
		clear_press_mask <= '0;
		clear_long_mask  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b111, 3'b000, 3'b000);
		send_tick(3'b010, 3'b111, 3'b111);
		send_tick(3'b101, 3'b000, 3'b000);
		item_valid <= 1'b0;
		drain();

		// zero thresholds: press, long and repeat on back-to-back ticks
		apply_config('0, '0, '0, 3'b000);
		send_tick(3'b111, 3'b000, 3'b000);
		send_tick(3'b111, 3'b000, 3'b000);
		send_tick(3'b111, 3'b000, 3'b000);
		send_tick(3'b111, 3'b111, 3'b000);
		send_tick(3'b111, 3'b000, 3'b111);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b101, 3'b000, 3'b000);
		send_tick(3'b101, 3'b000, 3'b000);
		send_tick(3'b101, 3'b101, 3'b010);
		send_tick(3'b010, 3'b000, 3'b000);
		send_tick(3'b010, 3'b000, 3'b000);
		send_tick(3'b010, 3'b111, 3'b111);
		item_valid <= 1'b0;
		drain();

		// active low pins with a bounce inside the debounce window
		apply_config(16'd1, 16'd2, 16'd1, 3'b111);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b011, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b000, 3'b000, 3'b000);
		send_tick(3'b111, 3'b111, 3'b111);
		item_valid <= 1'b0;

		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
			0: apply_config('0, '0, '0, 3'b000);
			1: apply_config('1, '1, '1, 3'b111);
			2: apply_config(16'd20, 16'd150, 16'd30, FIELD_W'($urandom_range(0, 7)));
			default: apply_config(ticks_t'($urandom_range(0, 8)), ticks_t'($urandom_range(0, 40)),
				ticks_t'($urandom_range(0, 12)), FIELD_W'($urandom_range(0, 7)));
			endcase
			noisy = ($urandom_range(0, 4) == 0);
			if (p == PRESSURE_PHASE) begin
				noisy    = 1'b0;
				hold_req = 1'b1;
			end
			run_phase((p == 1) ? 40 : PHASE_ITEMS, p == PRESSURE_PHASE);
		end
		drain();

		sb.report_leftover();
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+sv
sv/bdlp_pkg.sv
sv/bdlp_lane.sv
sv/bdlp_merge.sv
sv/button_debounce_long_press.sv
sim/tb_top.sv
